// ----- rtl/core/topic_subscriber_table_top_assert.svh -----
// Assertion macros for the topic subscriber table.
`ifndef TOPIC_SUBSCRIBER_TABLE_TOP_ASSERT_SVH
`define TOPIC_SUBSCRIBER_TABLE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sst assertion failed");
`define SST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sst assertion failed");
`else
`define SST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SST_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/sst_pkg.sv -----
// Shared types and constants for the topic subscriber table.
package sst_pkg;

	localparam int TOPIC_COUNT     = 256;
	localparam int SLOTS_PER_TOPIC = 8;
	localparam int ROW_W  = (TOPIC_COUNT > 1) ? $clog2(TOPIC_COUNT) : 1;
	localparam int SLOT_W = (SLOTS_PER_TOPIC > 1) ? $clog2(SLOTS_PER_TOPIC) : 1;

	typedef enum logic [1:0] {
		STAT_OK          = 2'd0,
		STAT_NO_HANDLER  = 2'd1,
		STAT_OTHER_GROUP = 2'd2,
		STAT_ROW_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0]  requester;
		logic [7:0]  group;
		logic [31:0] handler;
	} slot_t;

	typedef slot_t [SLOTS_PER_TOPIC-1:0] row_t;
	typedef logic [SLOTS_PER_TOPIC-1:0]  used_t;

	typedef struct packed {
		logic        mode;
		logic [7:0]  topic;
		logic [7:0]  group;
		logic [7:0]  requester;
		logic [31:0] handler;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic              wr_en;
		logic              set_slot;
		logic [SLOT_W-1:0] slot;
		used_t             used_new;
	} dec_t;

endpackage

// ----- rtl/core/topic_subscriber_table_top.sv -----
// Top level of the topic subscriber table: request channel, result register, control.
//
// Requests arrive on s_axis: tuser carries mode (0 subscribe, 1 unsubscribe),
// tdata carries topic, group, requester and handler address. Each accepted
// beat yields exactly one result beat on m_axis whose tdata holds the status
// (0 ok, 1 no handler, 2 registered under other group, 3 topic row full).
// The topic row is read from the row memories at the accepting edge, compared
// over all slots in parallel in the next cycle, written back and the status
// loaded into the output register at the end of that cycle unless a held
// result stalls it. m_axis_tvalid rises at that load; no new request is taken
// while one is in evaluation, as s_axis_tready is low outside idle.
// A result waiting in the output register does not block the next request;
// when the receiver stalls with a result still held, the next request stays
// in evaluation until the register frees, and s_axis_tready stays low.
// Reset clears the control state and marks every topic row as all free; no
// clearing pass is needed, so requests are taken from the first cycle.
`include "topic_subscriber_table_top_assert.svh"

module topic_subscriber_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,   // topic_id, group_id, requester_id, handler_address
	input  logic        s_axis_tuser,   // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // status, zero pad
);
	import sst_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EVAL = 2'b10
	} state_t;

	state_t  state_q;
	req_t    req_q;
	req_t    req_in;
	logic    accept;
	logic    done;
	used_t   used_rd;
	row_t    slots_rd;
	row_t    slots_wr;
	dec_t    dec;
	logic    m_tvalid_q;
	status_t status_q;

	assign req_in = '{
		mode:      s_axis_tuser,
		topic:     s_axis_tdata[7:0],
		group:     s_axis_tdata[15:8],
		requester: s_axis_tdata[23:16],
		handler:   s_axis_tdata[55:24]
	};

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign done          = (state_q == S_EVAL) && (!m_tvalid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (done) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_in;
		end
	end

	sst_row_mem u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_row   (req_in.topic[ROW_W-1:0]),
		.used_rd  (used_rd),
		.slots_rd (slots_rd),
		.wr_en    (done && dec.wr_en),
		.wr_row   (req_q.topic[ROW_W-1:0]),
		.wr_used  (dec.used_new),
		.wr_slots (slots_wr)
	);

	sst_slot_logic u_logic (
		.req   (req_q),
		.used  (used_rd),
		.slots (slots_rd),
		.dec   (dec)
	);

	always_comb begin
		slots_wr = slots_rd;
		if (dec.set_slot) begin
			slots_wr[dec.slot] = '{
				requester: req_q.requester,
				group:     req_q.group,
				handler:   req_q.handler
			};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status_q <= dec.status;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = {6'd0, status_q};

	`SST_ASSERT_NXT(a_accept_eval, clk, arst_n, accept, state_q == S_EVAL)
	`SST_ASSERT_NXT(a_done_result, clk, arst_n, done, m_axis_tvalid)
	`SST_ASSERT_IMP(a_write_ok, clk, arst_n, (state_q == S_EVAL) && dec.wr_en, dec.status == STAT_OK)
	`SST_ASSERT_IMP(a_no_handler, clk, arst_n, (state_q == S_EVAL) && (dec.status == STAT_NO_HANDLER),
		!req_q.mode && (req_q.handler == 32'd0))

endmodule

// ----- rtl/core/sst_row_mem.sv -----
// Row memories: used mask and slot contents per topic, registered read.
module sst_row_mem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [sst_pkg::ROW_W-1:0] rd_row,
	output sst_pkg::used_t            used_rd,
	output sst_pkg::row_t             slots_rd,
	input  logic                      wr_en,
	input  logic [sst_pkg::ROW_W-1:0] wr_row,
	input  sst_pkg::used_t            wr_used,
	input  sst_pkg::row_t             wr_slots
);
	import sst_pkg::*;

	used_t                  used_mem [TOPIC_COUNT];
	row_t                   slot_mem [TOPIC_COUNT];
	logic [TOPIC_COUNT-1:0] row_vld_q;
	used_t                  used_rd_q;
	row_t                   slots_rd_q;

	// rows never written read as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (wr_en) begin
			row_vld_q[wr_row] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			used_mem[wr_row] <= wr_used;
			slot_mem[wr_row] <= wr_slots;
		end
		if (rd_en) begin
			used_rd_q  <= row_vld_q[rd_row] ? used_mem[rd_row] : '0;
			slots_rd_q <= slot_mem[rd_row];
		end
	end

	assign used_rd  = used_rd_q;
	assign slots_rd = slots_rd_q;

endmodule

// ----- rtl/core/sst_slot_logic.sv -----
// Parallel slot compare and decision for one request.
module sst_slot_logic (
	input  sst_pkg::req_t  req,
	input  sst_pkg::used_t used,
	input  sst_pkg::row_t  slots,
	output sst_pkg::dec_t  dec
);
	import sst_pkg::*;

	logic              topic_ok;
	logic              req_hit;
	logic [SLOT_W-1:0] req_idx;
	logic              un_hit;
	logic [SLOT_W-1:0] un_idx;
	logic              free_any;
	logic [SLOT_W-1:0] free_idx;

	assign topic_ok = ({1'b0, req.topic} < 9'(TOPIC_COUNT));

	always_comb begin
		req_hit  = 1'b0;
		req_idx  = '0;
		un_hit   = 1'b0;
		un_idx   = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int s = 0; s < SLOTS_PER_TOPIC; s++) begin
			if (!req_hit && used[s] && slots[s].requester == req.requester) begin
				req_hit = 1'b1;
				req_idx = SLOT_W'(s);
			end
			if (!un_hit && used[s] && slots[s].requester == req.requester &&
				slots[s].group == req.group) begin
				un_hit = 1'b1;
				un_idx = SLOT_W'(s);
			end
			if (!used[s]) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(s);
			end
		end
	end

	always_comb begin
		dec          = '0;
		dec.status   = STAT_OK;
		dec.used_new = used;
		if (!req.mode) begin
			if (req.handler == 32'd0) begin
				dec.status = STAT_NO_HANDLER;
			end else if (!topic_ok) begin
				dec.status = STAT_ROW_FULL;
			end else if (req_hit) begin
				if (slots[req_idx].group != req.group) begin
					dec.status = STAT_OTHER_GROUP;
				end else begin
					dec.wr_en    = 1'b1;
					dec.set_slot = 1'b1;
					dec.slot     = req_idx;
				end
			end else if (free_any) begin
				dec.wr_en    = 1'b1;
				dec.set_slot = 1'b1;
				dec.slot     = free_idx;
			end else begin
				dec.status = STAT_ROW_FULL;
			end
			if (dec.set_slot) begin
				dec.used_new[dec.slot] = 1'b1;
			end
		end else if (topic_ok && un_hit) begin
			dec.wr_en             = 1'b1;
			dec.slot              = un_idx;
			dec.used_new[un_idx]  = 1'b0;
		end
	end

endmodule
